// ===== rtl/rsnep_pkg.sv =====
// ============================================================================
// rsnep_pkg
// Types, constants and suite decode functions for the RSN element parser.
// ============================================================================
package rsnep_pkg;

    localparam logic [7:0]  ELEM_TAG     = 8'h30;
    localparam logic [7:0]  VERSION_LO   = 8'h01;
    localparam logic [7:0]  VERSION_HI   = 8'h00;
    localparam logic [23:0] STD_OUI      = 24'h000FAC;

    // cipher suite types and mask bits
    localparam logic [7:0]  SUITE_TKIP     = 8'd2;
    localparam logic [7:0]  SUITE_CCMP     = 8'd4;
    localparam logic [7:0]  SUITE_GCMP256  = 8'd9;
    localparam logic [2:0]  CIPHER_TKIP    = 3'd1;
    localparam logic [2:0]  CIPHER_CCMP    = 3'd2;
    localparam logic [2:0]  CIPHER_GCMP256 = 3'd4;

    // AKM suite types and mask bits
    localparam logic [7:0]  AKM_PSK        = 8'd2;
    localparam logic [7:0]  AKM_PSK_SHA256 = 8'd6;
    localparam logic [7:0]  AKM_SAE        = 8'd8;
    localparam logic [7:0]  AKM_FT_SAE     = 8'd9;
    localparam logic [7:0]  AKM_SAE_EXT    = 8'd24;
    localparam logic [4:0]  AKMB_PSK        = 5'd1;
    localparam logic [4:0]  AKMB_PSK_SHA256 = 5'd2;
    localparam logic [4:0]  AKMB_SAE        = 5'd4;
    localparam logic [4:0]  AKMB_FT_SAE     = 5'd8;
    localparam logic [4:0]  AKMB_SAE_EXT    = 5'd16;

    typedef struct packed {
        logic [7:0] element_byte;
        logic       final_byte;
    } t_word;

    typedef struct packed {
        logic [7:0] group_mgmt_suite;
        logic       mfp_capable;
        logic       mfp_required;
        logic [4:0] akm_suites;
        logic [2:0] pairwise_ciphers;
        logic [2:0] group_cipher;
    } t_fields;

    typedef struct packed {
        logic    has_rsn;
        t_fields fields;
    } t_result;

    function automatic logic [2:0] cipher_bits(input logic [23:0] suite,
                                               input logic [7:0]  last);
        logic [2:0] bits;
        bits = '0;
        if (suite == STD_OUI) begin
            case (last)
                SUITE_TKIP:    bits = CIPHER_TKIP;
                SUITE_CCMP:    bits = CIPHER_CCMP;
                SUITE_GCMP256: bits = CIPHER_GCMP256;
                default:       bits = '0;
            endcase
        end
        return bits;
    endfunction

    function automatic logic [4:0] akm_bits(input logic [23:0] suite,
                                            input logic [7:0]  last);
        logic [4:0] bits;
        bits = '0;
        if (suite == STD_OUI) begin
            case (last)
                AKM_PSK:        bits = AKMB_PSK;
                AKM_PSK_SHA256: bits = AKMB_PSK_SHA256;
                AKM_SAE:        bits = AKMB_SAE;
                AKM_FT_SAE:     bits = AKMB_FT_SAE;
                AKM_SAE_EXT:    bits = AKMB_SAE_EXT;
                default:        bits = '0;
            endcase
        end
        return bits;
    endfunction

endpackage

// ===== rtl/rsnep_in_reg.sv =====
// ============================================================================
// rsnep_in_reg
// Input register: holds one buffer word until the parser takes it.
// ============================================================================
module rsnep_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rsnep_pkg::t_word i_word,
    output logic           o_valid,
    input  logic           i_take,
    output rsnep_pkg::t_word o_word
);

    logic            r_valid;
    rsnep_pkg::t_word r_word;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

// ===== rtl/rsnep_parser.sv =====
// ============================================================================
// rsnep_parser
// Per-word element state update and result register.
// ============================================================================
module rsnep_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_take,
    input  rsnep_pkg::t_word  i_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rsnep_pkg::t_result o_result
);

    localparam logic [3:0] PH_TAG   = 4'd0;
    localparam logic [3:0] PH_GROUP = 4'd1;
    localparam logic [3:0] PH_PCNT  = 4'd2;
    localparam logic [3:0] PH_PLIST = 4'd3;
    localparam logic [3:0] PH_ACNT  = 4'd4;
    localparam logic [3:0] PH_ALIST = 4'd5;
    localparam logic [3:0] PH_CAPS  = 4'd6;
    localparam logic [3:0] PH_KCNT  = 4'd7;
    localparam logic [3:0] PH_SKIP  = 4'd8;
    localparam logic [3:0] PH_GMGMT = 4'd9;
    localparam logic [3:0] PH_DONE  = 4'd10;

    logic [8:0]  r_pos,      n_pos;
    logic [8:0]  r_len,      n_len;
    logic [3:0]  r_phase,    n_phase;
    logic [15:0] r_remain,   n_remain;
    logic [20:0] r_skip_end, n_skip_end;
    logic [23:0] r_suite,    n_suite;
    logic [7:0]  r_cnt_lo,   n_cnt_lo;
    logic [7:0]  r_caps_lo,  n_caps_lo;
    logic        r_failed,   n_failed;
    logic [1:0]  r_part,     n_part;
    rsnep_pkg::t_fields r_fields, n_fields;

    logic               r_out_valid;
    rsnep_pkg::t_result r_result;

    logic [7:0]  w_b;
    logic [3:0]  w_phase;
    logic        w_room;
    logic        w_in_body;
    logic        w_ok;
    logic        w_fire;
    logic        w_done;

    assign w_b       = i_word.element_byte;
    assign w_room    = ({1'b0, r_pos} + 10'd4) <= {1'b0, r_len};
    assign w_in_body = (r_pos >= 9'd4) && (r_pos < r_len);
    assign o_take    = i_valid && (!i_word.final_byte || !r_out_valid || i_out_ready);
    assign w_fire    = o_take;
    assign w_done    = w_fire && i_word.final_byte;

    always_comb begin
        n_pos      = (&r_pos) ? r_pos : r_pos + 9'd1;
        n_len      = r_len;
        n_phase    = r_phase;
        n_remain   = r_remain;
        n_skip_end = r_skip_end;
        n_suite    = r_suite;
        n_cnt_lo   = r_cnt_lo;
        n_caps_lo  = r_caps_lo;
        n_failed   = r_failed;
        n_part     = r_part;
        n_fields   = r_fields;
        w_phase    = r_phase;

        if (r_pos == 9'd0 && w_b != rsnep_pkg::ELEM_TAG) begin
            n_failed = 1'b1;
        end
        if (r_pos == 9'd1) begin
            n_len = {1'b0, w_b} + 9'd2;
        end
        if (r_pos == 9'd2 && w_b != rsnep_pkg::VERSION_LO) begin
            n_failed = 1'b1;
        end
        if (r_pos == 9'd3) begin
            if (w_b != rsnep_pkg::VERSION_HI) begin
                n_failed = 1'b1;
            end
            n_phase = PH_GROUP;
            n_part  = 2'd0;
        end

        if (w_in_body) begin
            if (w_phase == PH_PLIST && r_part == 2'd0 && (r_remain == 16'd0 || !w_room)) begin
                w_phase = PH_ACNT;
            end
            if (w_phase == PH_ALIST && r_part == 2'd0 && (r_remain == 16'd0 || !w_room)) begin
                w_phase = PH_CAPS;
            end
            if (w_phase == PH_SKIP && {12'd0, r_pos} == r_skip_end) begin
                w_phase = w_room ? PH_GMGMT : PH_DONE;
            end
            n_phase = w_phase;

            case (w_phase)
                PH_GROUP, PH_PLIST, PH_ALIST, PH_GMGMT: begin
                    if (r_part != 2'd3) begin
                        n_suite = {r_suite[15:0], w_b};
                        n_part  = r_part + 2'd1;
                    end else begin
                        n_part = 2'd0;
                        case (w_phase)
                            PH_GROUP: begin
                                n_fields.group_cipher = r_fields.group_cipher
                                    | rsnep_pkg::cipher_bits(r_suite, w_b);
                                n_phase = PH_PCNT;
                            end
                            PH_PLIST: begin
                                n_fields.pairwise_ciphers = r_fields.pairwise_ciphers
                                    | rsnep_pkg::cipher_bits(r_suite, w_b);
                                n_remain = r_remain - 16'd1;
                            end
                            PH_ALIST: begin
                                n_fields.akm_suites = r_fields.akm_suites
                                    | rsnep_pkg::akm_bits(r_suite, w_b);
                                n_remain = r_remain - 16'd1;
                            end
                            default: begin
                                if (r_suite == rsnep_pkg::STD_OUI) begin
                                    n_fields.group_mgmt_suite = r_fields.group_mgmt_suite | w_b;
                                end
                                n_phase = PH_DONE;
                            end
                        endcase
                    end
                end
                PH_PCNT, PH_ACNT, PH_KCNT: begin
                    if (r_part == 2'd0) begin
                        n_cnt_lo = w_b;
                        n_part   = 2'd1;
                    end else begin
                        n_part   = 2'd0;
                        n_remain = {w_b, r_cnt_lo};
                        case (w_phase)
                            PH_PCNT: n_phase = PH_PLIST;
                            PH_ACNT: n_phase = PH_ALIST;
                            default: begin
                                n_skip_end = {12'd0, r_pos} + 21'd1
                                           + {1'b0, w_b, r_cnt_lo, 4'd0};
                                n_phase = PH_SKIP;
                            end
                        endcase
                    end
                end
                PH_CAPS: begin
                    if (r_part == 2'd0) begin
                        n_caps_lo = w_b;
                        n_part    = 2'd1;
                    end else begin
                        n_part = 2'd0;
                        n_fields.mfp_required = r_fields.mfp_required | r_caps_lo[6];
                        n_fields.mfp_capable  = r_fields.mfp_capable  | r_caps_lo[7];
                        n_phase = PH_KCNT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign w_ok = !n_failed && (n_len >= 9'd4) && (n_len <= n_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_done) begin
            r_pos      <= '0;
            r_len      <= '0;
            r_phase    <= PH_TAG;
            r_remain   <= '0;
            r_skip_end <= '0;
            r_suite    <= '0;
            r_cnt_lo   <= '0;
            r_caps_lo  <= '0;
            r_failed   <= 1'b0;
            r_part     <= '0;
            r_fields   <= '0;
        end else if (w_fire) begin
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_phase    <= n_phase;
            r_remain   <= n_remain;
            r_skip_end <= n_skip_end;
            r_suite    <= n_suite;
            r_cnt_lo   <= n_cnt_lo;
            r_caps_lo  <= n_caps_lo;
            r_failed   <= n_failed;
            r_part     <= n_part;
            r_fields   <= n_fields;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_result.has_rsn <= w_ok;
            r_result.fields  <= w_ok ? n_fields : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

// ===== rtl/rsn_element_parser.sv =====
// ============================================================================
// rsn_element_parser
// RSN element parser: one buffer byte per word, one result word per buffer.
//
// Channel  Dir  Handshake                 Payload
// in       in   i_in_valid / o_in_ready   i_element_byte, i_final_byte
// out      out  o_out_valid / i_out_ready o_has_rsn .. o_group_mgmt_suite
//
// One input word per cycle unless the input stalls; the final byte, once accepted,
// passes the input register, then one state update into the result reg.
// Reset clears all parse state and both valid flags.
// Input stalls only when the input register holds a final byte while the
// result register is full and not being taken.
// ============================================================================
module rsn_element_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_element_byte,
    input  logic       i_final_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_has_rsn,
    output logic [2:0] o_group_cipher,
    output logic [2:0] o_pairwise_ciphers,
    output logic [4:0] o_akm_suites,
    output logic       o_mfp_required,
    output logic       o_mfp_capable,
    output logic [7:0] o_group_mgmt_suite
);

    rsnep_pkg::t_word   w_in_word;
    rsnep_pkg::t_word   w_reg_word;
    rsnep_pkg::t_result w_result;
    logic               w_reg_valid;
    logic               w_take;

    assign w_in_word.element_byte = i_element_byte;
    assign w_in_word.final_byte   = i_final_byte;

    rsnep_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (w_in_word),
        .o_valid (w_reg_valid),
        .i_take  (w_take),
        .o_word  (w_reg_word)
    );

    rsnep_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_reg_valid),
        .o_take      (w_take),
        .i_word      (w_reg_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (w_result)
    );

    assign o_has_rsn          = w_result.has_rsn;
    assign o_group_cipher     = w_result.fields.group_cipher;
    assign o_pairwise_ciphers = w_result.fields.pairwise_ciphers;
    assign o_akm_suites       = w_result.fields.akm_suites;
    assign o_mfp_required     = w_result.fields.mfp_required;
    assign o_mfp_capable      = w_result.fields.mfp_capable;
    assign o_group_mgmt_suite = w_result.fields.group_mgmt_suite;

endmodule

// ===== rtl/rsnep_checker.sv =====
// ============================================================================
// rsnep_checker
// Port-level checks on the RSN element parser, bound to the top level.
// ============================================================================
module rsnep_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_has_rsn,
    input logic [2:0] o_group_cipher,
    input logic [2:0] o_pairwise_ciphers,
    input logic [4:0] o_akm_suites,
    input logic       o_mfp_required,
    input logic       o_mfp_capable,
    input logic [7:0] o_group_mgmt_suite
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("out valid after reset");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_has_rsn))
        else $error("out word dropped while stalled");

    a_fail_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_rsn |-> o_group_cipher == 3'd0
            && o_pairwise_ciphers == 3'd0 && o_akm_suites == 5'd0
            && !o_mfp_required && !o_mfp_capable && o_group_mgmt_suite == 8'd0)
        else $error("failed element has nonzero fields");

    a_group_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_group_cipher))
        else $error("group cipher has more than one bit");

endmodule

bind rsn_element_parser rsnep_checker u_rsnep_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_has_rsn          (o_has_rsn),
    .o_group_cipher     (o_group_cipher),
    .o_pairwise_ciphers (o_pairwise_ciphers),
    .o_akm_suites       (o_akm_suites),
    .o_mfp_required     (o_mfp_required),
    .o_mfp_capable      (o_mfp_capable),
    .o_group_mgmt_suite (o_group_mgmt_suite)
);
